[hdl/multi_button_press_debouncer_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the multi-button press debouncer
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef MULTI_BUTTON_PRESS_DEBOUNCER_MACROS_SVH
`define MULTI_BUTTON_PRESS_DEBOUNCER_MACROS_SVH

`ifndef SYNTHESIS
// Checked while reset is released.
`define MBPD_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, reset included.
`define MBPD_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MBPD_ASSERT(name, clk, rst_n, prop, msg)
`define MBPD_ASSERT_ALWAYS(name, clk, prop, msg)
`endif

`endif

[hdl/mbpd_pkg.sv]
// ----------------------------------------------------------------------------
// Debouncer package
// Shared widths, register and request codes, and inter-module types.
// ----------------------------------------------------------------------------
package mbpd_pkg;

  localparam int unsigned PORT_W     = 8;
  localparam int unsigned IDX_W      = 3;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 8;

  localparam int unsigned FIRST_BIT_DEF   = 0;
  localparam int unsigned NUM_BUTTONS_DEF = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_HIGH  = CFG_IDX_W'(1);

  localparam logic [CNT_W-1:0] DEBOUNCE_LEN_RST = CNT_W'(3);
  localparam logic             ACTIVE_HIGH_RST  = 1'b0;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_GET    = 1'b1
  } req_e;

  // Control from the top level to the merging stage.
  typedef struct packed {
    logic take;
    logic get;
  } ctl_t;

  typedef struct packed {
    logic              button_found;
    logic [IDX_W-1:0]  button_index;
    logic [PORT_W-1:0] pressed_flags;
  } res_t;

endpackage

[hdl/mbpd_if.sv]
// ----------------------------------------------------------------------------
// Debouncer channel interfaces
// Request, result and configuration write channels with valid/ready.
// ----------------------------------------------------------------------------
interface mbpd_req_if;
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [mbpd_pkg::PORT_W-1:0]  port_bits;

  modport source (output valid, req_type, port_bits, input ready);
  modport sink   (input valid, req_type, port_bits, output ready);
endinterface

interface mbpd_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         button_found;
  logic [mbpd_pkg::IDX_W-1:0]   button_index;
  logic [mbpd_pkg::PORT_W-1:0]  pressed_flags;

  modport source (output valid, button_found, button_index, pressed_flags, input ready);
  modport sink   (input valid, button_found, button_index, pressed_flags, output ready);
endinterface

interface mbpd_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [mbpd_pkg::CFG_IDX_W-1:0]   index;
  logic [mbpd_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hdl/mbpd_lane.sv]
// ----------------------------------------------------------------------------
// Debouncer button lane
// Counts consecutive down samples of one button and flags the press sample.
// ----------------------------------------------------------------------------
`include "multi_button_press_debouncer_macros.svh"

module mbpd_lane (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       sample_i,
  input  logic                       down_i,
  input  logic [mbpd_pkg::CNT_W-1:0] debounce_len_i,
  output logic                       set_o
);

  logic [mbpd_pkg::CNT_W-1:0] cnt_q, cnt_d;

  // The press fires on the sample that finds the count at the threshold.
  assign set_o = sample_i && down_i && (cnt_q == debounce_len_i);

  always_comb begin
    cnt_d = cnt_q;
    if (sample_i) begin
      if (!down_i) begin
        cnt_d = '0;
      end else if ((cnt_q <= debounce_len_i) && (cnt_q != '1)) begin
        cnt_d = cnt_q + mbpd_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  `MBPD_ASSERT(a_up_clears, clk_i, rst_ni, (sample_i && !down_i) |=> (cnt_q == '0), "up sample did not clear count")
  `MBPD_ASSERT(a_idle_holds, clk_i, rst_ni, !sample_i |=> $stable(cnt_q), "count moved without a sample")

endmodule

[hdl/mbpd_merge.sv]
// ----------------------------------------------------------------------------
// Debouncer merging stage
// Folds lane press events into the sticky flags, serves get requests by
// lowest pending button, and buffers results in a two-entry queue.
// ----------------------------------------------------------------------------
`include "multi_button_press_debouncer_macros.svh"

module mbpd_merge (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  mbpd_pkg::ctl_t              ctl_i,
  input  logic [mbpd_pkg::PORT_W-1:0] set_mask_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output mbpd_pkg::res_t              out_res_o
);

  logic [mbpd_pkg::PORT_W-1:0] pend_q, pend_d;
  logic                        found;
  logic [mbpd_pkg::IDX_W-1:0]  idx;
  mbpd_pkg::res_t              res;

  mbpd_pkg::res_t buf_q [2];
  logic           wr_ptr_q, rd_ptr_q;
  logic [1:0]     cnt_q, cnt_d;
  logic           pop;

  always_comb begin
    found  = 1'b0;
    idx    = '0;
    pend_d = pend_q;
    if (ctl_i.get) begin
      // Scan from the top so the lowest set bit wins.
      for (int b = mbpd_pkg::PORT_W - 1; b >= 0; b--) begin
        if (pend_q[b]) begin
          found = 1'b1;
          idx   = mbpd_pkg::IDX_W'(b);
        end
      end
      if (found) begin
        pend_d[idx] = 1'b0;
      end
    end else begin
      pend_d = pend_q | set_mask_i;
    end
  end

  assign res.button_found  = found;
  assign res.button_index  = idx;
  assign res.pressed_flags = pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (ctl_i.take) begin
      pend_q <= pend_d;
    end
  end

  // Result queue.
  assign in_ready_o  = (cnt_q != 2'd2);
  assign out_valid_o = (cnt_q != 2'd0);
  assign pop         = out_valid_o && out_ready_i;
  assign out_res_o   = buf_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.take && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!ctl_i.take && pop) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (ctl_i.take) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.take) begin
      buf_q[wr_ptr_q] <= res;
    end
  end

  `MBPD_ASSERT_ALWAYS(a_cnt_range, clk_i, cnt_q != 2'd3, "result queue count out of range")
  `MBPD_ASSERT(a_sample_keeps_flags, clk_i, rst_ni, (ctl_i.take && !ctl_i.get) |=> ((pend_q & $past(pend_q)) == $past(pend_q)), "sample cleared a press flag")
  `MBPD_ASSERT(a_get_clears_one, clk_i, rst_ni, (ctl_i.take && ctl_i.get) |=> ($countones($past(pend_q) & ~pend_q) <= 1), "get cleared more than one flag")

endmodule

[hdl/multi_button_press_debouncer.sv]
// ----------------------------------------------------------------------------
// Multi-button press debouncer
// Up to eight button lanes count consecutive down samples; a press is latched
// as a sticky flag and handed out, lowest button first, by get requests.
// ----------------------------------------------------------------------------
// The lanes and the flag register update at the transfer edge of a request
// and the result enters a two-entry output queue, so one request per cycle
// is accepted for as long as results are taken, and one more is accepted
// while a result waits. Each lane is its own counter and the only shared
// path is the eight-bit lowest-flag pick. Configuration writes are always
// ready; index 0 is the debounce length (down samples needed for a press,
// minus one), index 1 is active_high.

module multi_button_press_debouncer #(
  parameter int unsigned FIRST_BIT   = mbpd_pkg::FIRST_BIT_DEF,
  parameter int unsigned NUM_BUTTONS = mbpd_pkg::NUM_BUTTONS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  mbpd_cfg_if.sink   cfg_i,
  mbpd_req_if.sink   req_i,
  mbpd_rsp_if.source rsp_o
);

  logic [mbpd_pkg::CNT_W-1:0]  debounce_len_q;
  logic                        active_high_q;
  logic [mbpd_pkg::PORT_W-1:0] level;
  logic [mbpd_pkg::PORT_W-1:0] set_mask;
  logic                        in_ready;
  logic                        sample;
  mbpd_pkg::ctl_t              ctl;
  mbpd_pkg::res_t              res;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_len_q <= mbpd_pkg::DEBOUNCE_LEN_RST;
      active_high_q  <= mbpd_pkg::ACTIVE_HIGH_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        mbpd_pkg::REG_DEBOUNCE_LEN: debounce_len_q <= cfg_i.data[mbpd_pkg::CNT_W-1:0];
        mbpd_pkg::REG_ACTIVE_HIGH:  active_high_q  <= cfg_i.data[0];
        default: ;
      endcase
    end
  end

  assign req_i.ready = in_ready;
  assign ctl.take    = req_i.valid && in_ready;
  assign ctl.get     = (req_i.req_type == mbpd_pkg::REQ_GET);
  assign sample      = ctl.take && !ctl.get;
  assign level       = active_high_q ? req_i.port_bits : ~req_i.port_bits;

  // Port bits outside the configured button window have no lane.
  for (genvar b = 0; b < mbpd_pkg::PORT_W; b++) begin : g_bit
    if ((b >= FIRST_BIT) && (b - FIRST_BIT < NUM_BUTTONS)) begin : g_lane
      mbpd_lane u_lane (
        .clk_i          (clk_i),
        .rst_ni         (rst_ni),
        .sample_i       (sample),
        .down_i         (level[b]),
        .debounce_len_i (debounce_len_q),
        .set_o          (set_mask[b])
      );
    end else begin : g_none
      assign set_mask[b] = 1'b0;
    end
  end

  mbpd_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .set_mask_i  (set_mask),
    .in_ready_o  (in_ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .out_res_o   (res)
  );

  assign rsp_o.button_found  = res.button_found;
  assign rsp_o.button_index  = res.button_index;
  assign rsp_o.pressed_flags = res.pressed_flags;

endmodule

[tb/sv/mbpd_press_monitor.sv]
// ----------------------------------------------------------------------------
// Debouncer press monitor
// Watches the configuration, request and result channels, keeps its own copy
// of the lane counters and press flags, and compares every result transfer
// with the oldest predicted result.
// ----------------------------------------------------------------------------
module mbpd_press_monitor #(
  parameter int unsigned FIRST_BIT   = mbpd_pkg::FIRST_BIT_DEF,
  parameter int unsigned NUM_BUTTONS = mbpd_pkg::NUM_BUTTONS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  mbpd_cfg_if  cfg_i,
  mbpd_req_if  req_i,
  mbpd_rsp_if  rsp_i,
  output int   errors_o,
  output int   outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import mbpd_pkg::*;

  localparam int MAX_REPORTS = 10;

  logic [CNT_W-1:0]  down_count [8];
  logic [PORT_W-1:0] press_flags;
  logic [CNT_W-1:0]  debounce_len;
  logic              active_high;
  res_t              pending_results [$];
  int                fail_count = 0;

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%0t: %s", $realtime, msg);
    end
  endfunction

  // Updates the lane counters and flags for one request and returns its result.
  function automatic res_t debounce_request(input req_e kind,
                                            input logic [PORT_W-1:0] port_bits);
    res_t              r;
    logic [PORT_W-1:0] down;
    int unsigned       pin;
    r = '0;
    if (kind == REQ_SAMPLE) begin
      down = active_high ? port_bits : ~port_bits;
      for (int lane = 0; lane < int'(NUM_BUTTONS) && lane < 8; lane++) begin
        pin = FIRST_BIT + lane;
        // Lanes that would sit above the top port bit do not exist.
        if (pin < PORT_W) begin
          if (down[pin]) begin
            if (down_count[lane] == debounce_len) begin
              press_flags[pin] = 1'b1;
            end
            if (down_count[lane] <= debounce_len && down_count[lane] != '1) begin
              down_count[lane] = down_count[lane] + 1'b1;
            end
          end else begin
            down_count[lane] = '0;
          end
        end
      end
    end else begin
      for (int b = 0; b < PORT_W; b++) begin
        if (!r.button_found && press_flags[b]) begin
          press_flags[b]  = 1'b0;
          r.button_found = 1'b1;
          r.button_index = IDX_W'(b);
        end
      end
    end
    r.pressed_flags = press_flags;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    if (!rst_ni) begin
      for (int l = 0; l < 8; l++) begin
        down_count[l] = '0;
      end
      press_flags  = '0;
      debounce_len = DEBOUNCE_LEN_RST;
      active_high  = ACTIVE_HIGH_RST;
      pending_results.delete();
      outstanding_o <= 0;
      errors_o      <= fail_count;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          REG_DEBOUNCE_LEN: debounce_len = cfg_i.data;
          REG_ACTIVE_HIGH:  active_high  = cfg_i.data[0];
          default: ;
        endcase
      end
      // The request is recorded first so that a result leaving in the same
      // cycle as its own request would still find it.
      if (req_i.valid && req_i.ready) begin
        pending_results.push_back(debounce_request(req_e'(req_i.req_type), req_i.port_bits));
      end
      if (rsp_i.valid && rsp_i.ready) begin
        got.button_found  = rsp_i.button_found;
        got.button_index  = rsp_i.button_index;
        got.pressed_flags = rsp_i.pressed_flags;
        if (pending_results.size() == 0) begin
          note_failure($sformatf("result transfer with no request waiting: found=%0d index=%0d flags=%02h",
                                 got.button_found, got.button_index, got.pressed_flags));
        end else begin
          want = pending_results.pop_front();
          if (got.button_found !== want.button_found ||
              got.button_index !== want.button_index ||
              got.pressed_flags !== want.pressed_flags) begin
            note_failure($sformatf({"result mismatch: expected found=%0d index=%0d flags=%02h,",
                                    " got found=%0d index=%0d flags=%02h"},
                                   want.button_found, want.button_index, want.pressed_flags,
                                   got.button_found, got.button_index, got.pressed_flags));
          end
        end
      end
      outstanding_o <= pending_results.size();
      errors_o      <= fail_count;
    end
  end

endmodule

[tb/sv/multi_button_press_debouncer_tb.sv]
// ----------------------------------------------------------------------------
// Multi-button press debouncer testbench
// Drives directed and random sample and get requests through several
// debounce settings and polarities while both channel sides stall at random;
// the press monitor predicts and checks every result.
// ----------------------------------------------------------------------------
module multi_button_press_debouncer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mbpd_pkg::*;

  logic clk = 1'b0;
  logic rst_n;

  int fail_count;
  int outstanding;
  int send_idle_pct;
  int recv_idle_pct;
  int hold_requests = 0;
  int holds_served  = 0;
  int stall_left    = 0;

  logic              cur_active_high;
  logic [PORT_W-1:0] held_down;

  mbpd_cfg_if cfg_if ();
  mbpd_req_if req_if ();
  mbpd_rsp_if rsp_if ();

  multi_button_press_debouncer dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  mbpd_press_monitor u_press_monitor (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_i         (cfg_if),
    .req_i         (req_if),
    .rsp_i         (rsp_if),
    .errors_o      (fail_count),
    .outstanding_o (outstanding)
  );

  always #5 clk = ~clk;

  initial begin
    #2ms;
    $display("multi_button_press_debouncer_tb failed");
    $finish;
  end

  // Result side: random stalls, plus a long hold-off whenever one is requested.
  always @(posedge clk) begin
    if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      stall_left   = 60;
    end
    if (stall_left > 0) begin
      stall_left--;
      rsp_if.ready <= 1'b0;
    end else begin
      rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Returns at the edge where the request transfer happens, with valid still high.
  task automatic send_item(input req_e kind, input logic [PORT_W-1:0] bits);
    if ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_if.valid     <= 1'b1;
    req_if.req_type  <= kind;
    req_if.port_bits <= bits;
    do @(posedge clk); while (!req_if.ready);
  endtask

  task automatic drain();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [CFG_DATA_W-1:0] debounce_len, input logic active_high);
    drain();
    cfg_if.valid <= 1'b1;
    cfg_if.index <= REG_DEBOUNCE_LEN;
    cfg_if.data  <= debounce_len;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.index <= REG_ACTIVE_HIGH;
    cfg_if.data  <= CFG_DATA_W'(active_high);
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    cur_active_high = active_high;
  endtask

  // Samples mostly follow a slowly changing set of held buttons, with some
  // single-bit bounce and some fully random ports mixed in.
  task automatic send_random(input int count, input int chg_permille, input int noise_pct,
                             input int get_pct);
    logic [PORT_W-1:0] down;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < get_pct) begin
        send_item(REQ_GET, PORT_W'($urandom));
      end else begin
        if ($urandom_range(999) < chg_permille) begin
          held_down[$urandom_range(PORT_W-1)] ^= 1'b1;
        end
        if ($urandom_range(3999) < chg_permille) begin
          held_down = PORT_W'($urandom);
        end
        down = held_down;
        if ($urandom_range(99) < noise_pct) begin
          down[$urandom_range(PORT_W-1)] ^= 1'b1;
        end
        if ($urandom_range(199) < noise_pct) begin
          down = PORT_W'($urandom);
        end
        send_item(REQ_SAMPLE, cur_active_high ? down : ~down);
      end
    end
  endtask

  initial begin
    rst_n            <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.index     <= REG_DEBOUNCE_LEN;
    cfg_if.data      <= '0;
    req_if.valid     <= 1'b0;
    req_if.req_type  <= REQ_SAMPLE;
    req_if.port_bits <= '0;
    held_down        = '0;
    cur_active_high  = ACTIVE_HIGH_RST;
    send_idle_pct    = 10;
    recv_idle_pct    = 78;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset setting: a press needs four down samples in
    // a row, and a low port bit means down.
    send_item(REQ_GET, 8'hA5);
    send_item(REQ_SAMPLE, 8'hFF);
    repeat (5) send_item(REQ_SAMPLE, 8'h00);
    send_item(REQ_GET, 8'h00);
    send_item(REQ_SAMPLE, 8'hFF);
    send_item(REQ_GET, 8'hFF);
    repeat (4) send_item(REQ_SAMPLE, 8'h5A);
    send_item(REQ_SAMPLE, 8'h7F);
    repeat (4) send_item(REQ_SAMPLE, 8'h01);
    repeat (8) send_item(REQ_GET, 8'h00);

    reconfigure(8'd0, 1'b1);
    send_random(25, 150, 10, 25);
    reconfigure(8'd1, 1'b0);
    send_random(25, 120, 10, 25);

    send_idle_pct = 78;
    recv_idle_pct = 10;
    reconfigure(8'd2, 1'b1);
    send_random(25, 100, 10, 25);
    reconfigure(8'd6, 1'b0);
    send_random(25, 60, 8, 25);

    // Largest setting: a held button needs a long run of down samples, and
    // the result side stops for a while so that the input backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    reconfigure(8'd255, 1'b1);
    hold_requests <= hold_requests + 1;
    send_random(320, 4, 1, 5);
    // Counters left above the new setting stay put until the button is let go.
    reconfigure(8'd1, 1'b1);
    send_random(20, 100, 10, 25);

    drain();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("multi_button_press_debouncer_tb passed");
    end else begin
      $display("multi_button_press_debouncer_tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/mbpd_pkg.sv
hdl/mbpd_if.sv
hdl/mbpd_lane.sv
hdl/mbpd_merge.sv
hdl/multi_button_press_debouncer.sv
tb/sv/mbpd_press_monitor.sv
tb/sv/multi_button_press_debouncer_tb.sv
